FILE: rtl/lsba_pkg.sv
// Shared types, constants and the sector classifier for the lidar sector binning block.
// No dependencies; imported by every module of the block.
package lsba_pkg;

   localparam int DIST_W   = 16;
   localparam int ANGLE_W  = 15;
   localparam int QUAL_W   = 6;
   localparam int SECTOR_W = 3;
   localparam int SECTORS  = 8;
   localparam int CNT_W    = 5;
   localparam int SUM_W    = 21;
   localparam int CSR_W    = 16;

   // Angles in 1/64 degree.
   localparam int ANGLE_SECTOR      = 2880;
   localparam int ANGLE_HALF_SECTOR = 1440;
   localparam int ANGLE_WRAP_START  = 21600;

   localparam logic [QUAL_W-1:0] QUALITY_MIN_RST  = 6'd10;
   localparam logic [QUAL_W-1:0] QUALITY_MAX_RST  = 6'd25;
   localparam logic [DIST_W-1:0] DISTANCE_MIN_RST = 16'd600;
   localparam logic [DIST_W-1:0] DISTANCE_MAX_RST = 16'd40000;

   typedef enum logic [1:0] {
      CSR_QUALITY_MIN  = 2'd0,
      CSR_QUALITY_MAX  = 2'd1,
      CSR_DISTANCE_MIN = 2'd2,
      CSR_DISTANCE_MAX = 2'd3
   } csr_index_type;

   // One kept point on its way from classifier to accumulator.
   typedef struct packed {
      logic [SECTOR_W-1:0] sector;
      logic [DIST_W-1:0]   distance;
   } point_type;

   // Sector 0 is centred on 0 deg and also takes everything from 337.5 deg up.
   function automatic logic [SECTOR_W-1:0] sector_of(input logic [ANGLE_W-1:0] angle);
      logic [SECTOR_W-1:0] s;
      s = '0;
      if (angle < ANGLE_W'(ANGLE_WRAP_START)) begin
         for (int i = 1; i < SECTORS; i++) begin
            if (angle >= ANGLE_W'(i * ANGLE_SECTOR - ANGLE_HALF_SECTOR)) begin
               s = SECTOR_W'(i);
            end
         end
      end
      return s;
   endfunction

endpackage

FILE: rtl/lidar_sector_binning_average.sv
// Lidar sector binning: filters points by quality/distance windows, bins them into
// eight 45-degree sectors and emits a sector's mean distance once it holds PACKET_SIZE kept points.
// Throughput: one req beat per cycle while the queue is not full; the accumulator does one
// table read-modify-write per cycle unless rsp back-pressure stalls it. A point that completes a
// sector passes the queue write, table update and reciprocal multiply registers before rsp_valid.
// Synchronous active-high reset restores the window defaults and clears every sector at once.
module lidar_sector_binning_average #(
   parameter int PACKET_SIZE = 20,  // points per emitted mean, 1..31
   parameter int QUEUE_DEPTH = 4    // front/back decoupling queue entries
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration writes, to be made only while idle; the block does not enforce this
   input  logic                          csr_we,
   input  lsba_pkg::csr_index_type       csr_index,
   input  logic [lsba_pkg::CSR_W-1:0]    csr_wdata,
   // point beats
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lsba_pkg::DIST_W-1:0]   req_point_distance,
   input  logic [lsba_pkg::ANGLE_W-1:0]  req_point_angle,
   input  logic [lsba_pkg::QUAL_W-1:0]   req_point_quality,
   // sector mean beats
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lsba_pkg::SECTOR_W-1:0] rsp_sector_index,
   output logic [lsba_pkg::DIST_W-1:0]   rsp_mean_distance
);
   import lsba_pkg::*;

   // Front -> queue: only kept points are queued, rejected beats vanish here.
   logic      q_push, q_full, q_pop, q_valid;
   point_type q_in, q_out;

   lsba_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_point_distance (req_point_distance),
      .req_point_angle    (req_point_angle),
      .req_point_quality  (req_point_quality),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (q_in)
   );

   // Lets the front keep taking beats while the rsp side is stalled, until the queue is full.
   lsba_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_out)
   );

   // Table update and mean computation; stalls the queue only when its
   // two output stages are both occupied.
   lsba_back #(
      .PACKET_SIZE (PACKET_SIZE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_data            (q_out),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sector_index  (rsp_sector_index),
      .rsp_mean_distance (rsp_mean_distance)
   );

endmodule

FILE: rtl/lsba_front.sv
// Front end: window registers, point filter and sector classifier.
// Depends on lsba_pkg; feeds lsba_queue.
module lsba_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  lsba_pkg::csr_index_type     csr_index,
   input  logic [lsba_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lsba_pkg::DIST_W-1:0] req_point_distance,
   input  logic [lsba_pkg::ANGLE_W-1:0] req_point_angle,
   input  logic [lsba_pkg::QUAL_W-1:0] req_point_quality,
   input  logic                        q_full,
   output logic                        q_push,
   output lsba_pkg::point_type         q_data
);
   import lsba_pkg::*;

   logic [QUAL_W-1:0] qmin_ff, qmax_ff;
   logic [DIST_W-1:0] dmin_ff, dmax_ff;
   logic              keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         qmin_ff <= QUALITY_MIN_RST;
         qmax_ff <= QUALITY_MAX_RST;
         dmin_ff <= DISTANCE_MIN_RST;
         dmax_ff <= DISTANCE_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUALITY_MIN:  qmin_ff <= csr_wdata[QUAL_W-1:0];
            CSR_QUALITY_MAX:  qmax_ff <= csr_wdata[QUAL_W-1:0];
            CSR_DISTANCE_MIN: dmin_ff <= csr_wdata[DIST_W-1:0];
            CSR_DISTANCE_MAX: dmax_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // Both windows inclusive; an inverted window keeps nothing.
   assign keep = (req_point_quality >= qmin_ff) && (req_point_quality <= qmax_ff) &&
                 (req_point_distance >= dmin_ff) && (req_point_distance <= dmax_ff);

   assign req_ready       = !q_full;
   assign q_push          = req_valid && req_ready && keep;
   assign q_data.sector   = sector_of(req_point_angle);
   assign q_data.distance = req_point_distance;

endmodule

FILE: rtl/lsba_queue.sv
// Small register FIFO between the classifier and the accumulator.
// Depends on lsba_pkg (point_type).
module lsba_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lsba_pkg::point_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output lsba_pkg::point_type pop_data
);
   import lsba_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   point_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;

   assign full     = count_ff == CNT_QW'(DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_QW'(DEPTH)) else $error("queue count past depth");

endmodule

FILE: rtl/lsba_back.sv
// Back end: per-sector count/sum table and the mean pipeline (reciprocal multiply).
// Depends on lsba_pkg; drains lsba_queue and drives the rsp channel.
module lsba_back #(
   parameter int PACKET_SIZE = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  lsba_pkg::point_type           q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lsba_pkg::SECTOR_W-1:0] rsp_sector_index,
   output logic [lsba_pkg::DIST_W-1:0]   rsp_mean_distance
);
   import lsba_pkg::*;

   // floor(x*RECIP >> SHIFT) == floor(x / PACKET_SIZE) for all x below 2**SUM_W.
   localparam int SHIFT    = SUM_W + $clog2(PACKET_SIZE);
   localparam int RECIP_W  = SHIFT + 1;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((65'd1 << SHIFT) + 65'(PACKET_SIZE) - 65'd1) / 65'(PACKET_SIZE));

   logic [CNT_W-1:0]    count_ff [SECTORS];
   logic [SUM_W-1:0]    sum_ff   [SECTORS];
   logic [CNT_W-1:0]    cnt_in;
   logic [SUM_W-1:0]    sum_in;
   logic                done;

   logic                a_valid_ff, b_valid_ff;
   logic [SUM_W-1:0]    a_sum_ff;
   logic [SECTOR_W-1:0] a_sector_ff, b_sector_ff;
   logic [PROD_W-1:0]   b_prod_ff, b_prod_in;
   logic                a_ready, b_ready;

   assign b_ready = !b_valid_ff || rsp_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign q_pop   = q_valid && a_ready;

   assign cnt_in = count_ff[q_data.sector] + 1'b1;
   assign sum_in = sum_ff[q_data.sector] + SUM_W'(q_data.distance);
   assign done   = cnt_in == CNT_W'(PACKET_SIZE);

   assign b_prod_in = PROD_W'(a_sum_ff) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECTORS; i++) begin
            count_ff[i] <= '0;
            sum_ff[i]   <= '0;
         end
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            count_ff[q_data.sector] <= done ? '0 : cnt_in;
            sum_ff[q_data.sector]   <= done ? '0 : sum_in;
         end
         if (a_ready) begin
            a_valid_ff <= q_pop && done;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && done) begin
         a_sum_ff    <= sum_in;
         a_sector_ff <= q_data.sector;
      end
      if (b_ready && a_valid_ff) begin
         b_prod_ff   <= b_prod_in;
         b_sector_ff <= a_sector_ff;
      end
   end

   assign rsp_valid         = b_valid_ff;
   assign rsp_sector_index  = b_sector_ff;
   assign rsp_mean_distance = b_prod_ff[SHIFT +: DIST_W];

   a_count_below_packet: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff[q_data.sector] < CNT_W'(PACKET_SIZE))
      else $error("sector count at or past packet size");
   a_sector_cleared: assert property (@(posedge clock) disable iff (reset)
      q_pop && done |=> count_ff[$past(q_data.sector)] == '0 &&
                        sum_ff[$past(q_data.sector)] == '0)
      else $error("full sector not cleared");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_ready |=> a_valid_ff && $stable(a_sum_ff) && $stable(a_sector_ff))
      else $error("sum stage lost data under stall");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for lidar_sector_binning_average: point beats in, sector means out.
// Depends on lsba_pkg and the block's RTL; predicts every mean from its own copy of the bins.
module testbench;
   import lsba_pkg::*;

   localparam int POINTS_PER_MEAN = 20;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 16;    // the pipe stages plus the 4-entry queue, with slack
   localparam int IDLE_PCT        = 17;
   localparam int RANDOM_POINTS   = 510;
   localparam int PHASE_POINTS    = 85;
   localparam int HOLD_CYCLES     = 400;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      logic [SECTOR_W-1:0] sector;
      logic [DIST_W-1:0]   mean;
   } sector_mean_type;

   // DUT ports; the inputs driven here are known from time zero
   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                csr_we             = 1'b0;
   csr_index_type       csr_index          = CSR_QUALITY_MIN;
   logic [CSR_W-1:0]    csr_wdata          = '0;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [DIST_W-1:0]   req_point_distance = '0;
   logic [ANGLE_W-1:0]  req_point_angle    = '0;
   logic [QUAL_W-1:0]   req_point_quality  = '0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [SECTOR_W-1:0] rsp_sector_index;
   logic [DIST_W-1:0]   rsp_mean_distance;

   // Predictor state: acceptance windows and the per-sector bins
   logic [QUAL_W-1:0]   win_qmin = QUALITY_MIN_RST;
   logic [QUAL_W-1:0]   win_qmax = QUALITY_MAX_RST;
   logic [DIST_W-1:0]   win_dmin = DISTANCE_MIN_RST;
   logic [DIST_W-1:0]   win_dmax = DISTANCE_MAX_RST;
   logic [CNT_W-1:0]    bin_count [SECTORS] = '{default: '0};
   logic [SUM_W-1:0]    bin_sum   [SECTORS] = '{default: '0};

   sector_mean_type     pending_means [$];

   bit                  idle_on          = 1'b1;  // random gaps on both channels
   int                  rsp_hold_request = 0;     // handed to the receiver process
   int                  rsp_hold_left    = 0;
   int                  cycle_count      = 0;
   int                  points_taken     = 0;
   int                  means_predicted  = 0;
   int                  means_checked    = 0;
   int                  mismatch_count   = 0;
   int                  settings_used    = 1;     // reset windows count as the first

   lidar_sector_binning_average #(.PACKET_SIZE(POINTS_PER_MEAN)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_point_distance(req_point_distance),
      .req_point_angle   (req_point_angle),
      .req_point_quality (req_point_quality),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sector_index  (rsp_sector_index),
      .rsp_mean_distance (rsp_mean_distance)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Bin one point; returns 1 and the mean when the point fills its sector.
   function automatic bit bin_point(input logic [DIST_W-1:0] point_dist,
                                    input logic [ANGLE_W-1:0] angle,
                                    input logic [QUAL_W-1:0] qual,
                                    output sector_mean_type mean_out);
      int s;
      mean_out.sector = '0;
      mean_out.mean   = '0;
      if (qual < win_qmin || qual > win_qmax) return 1'b0;
      if (point_dist < win_dmin || point_dist > win_dmax) return 1'b0;
      // sector 0 wraps: 337.5 deg and up, including angles past 360 deg
      if (angle >= ANGLE_WRAP_START) s = 0;
      else s = ((int'(angle) + ANGLE_HALF_SECTOR) / ANGLE_SECTOR) % SECTORS;
      if (bin_count[s] >= POINTS_PER_MEAN) return 1'b0;
      bin_count[s] = bin_count[s] + 1'b1;
      bin_sum[s]   = bin_sum[s] + point_dist;
      if (bin_count[s] == POINTS_PER_MEAN) begin
         mean_out.sector = SECTOR_W'(s);
         mean_out.mean   = DIST_W'(bin_sum[s] / POINTS_PER_MEAN);
         bin_count[s]    = '0;
         bin_sum[s]      = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Monitor: predict on every req beat, check every rsp beat against the oldest mean due.
   // Both sampled at the edge, before this edge's updates land.
   always @(posedge clock) begin
      sector_mean_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            points_taken++;
            if (bin_point(req_point_distance, req_point_angle, req_point_quality, due)) begin
               pending_means.push_back(due);
               means_predicted++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_means.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected rsp beat: sector %0d mean %0d",
                           rsp_sector_index, rsp_mean_distance);
            end else begin
               due = pending_means.pop_front();
               means_checked++;
               if (rsp_sector_index !== due.sector || rsp_mean_distance !== due.mean) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("rsp beat %0d: expected sector %0d mean %0d, got sector %0d mean %0d",
                              means_checked, due.sector, due.mean,
                              rsp_sector_index, rsp_mean_distance);
               end
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold when a test asks for one.
   always @(posedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99, 0) < IDLE_PCT);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d sector means outstanding",
               cycle_count, pending_means.size());
      $display("lidar_sector_binning_average: mismatch");
      $finish;
   end

   // One point beat. Called at a clock edge, returns at the edge where it is taken.
   task automatic send_point(input int point_dist, input int angle, input int qual);
      while (idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_point_distance <= DIST_W'(point_dist);
      req_point_angle    <= ANGLE_W'(angle);
      req_point_quality  <= QUAL_W'(qual);
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // A point inside the current windows, mostly aimed at one sector so means come often.
   task automatic send_binned(input int hot_sector);
      int point_dist, qual, angle, s;
      case ($urandom_range(7, 0))
         0:       point_dist = win_dmin;
         1:       point_dist = win_dmax;
         default: point_dist = $urandom_range(win_dmax, win_dmin);
      endcase
      case ($urandom_range(7, 0))
         0:       qual = win_qmin;
         1:       qual = win_qmax;
         default: qual = $urandom_range(win_qmax, win_qmin);
      endcase
      s = ($urandom_range(3, 0) != 0) ? hot_sector : $urandom_range(7, 0);
      if (s == 0 && $urandom_range(3, 0) == 0)
         angle = $urandom_range(32767, ANGLE_WRAP_START);  // wrap side, past 360 deg too
      else
         angle = (s * ANGLE_SECTOR - ANGLE_HALF_SECTOR + $urandom_range(ANGLE_SECTOR - 1, 0)
                  + SECTORS * ANGLE_SECTOR) % (SECTORS * ANGLE_SECTOR);
      send_point(point_dist, angle, qual);
   endtask

   task automatic send_noise();
      send_point($urandom_range(65535, 0), $urandom_range(32767, 0), $urandom_range(63, 0));
   endtask

   // Sender stops until every mean due is back, then lets the queue drain of points that complete no mean.
   task automatic drain_means();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_means.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      case (idx)
         CSR_QUALITY_MIN:  win_qmin = QUAL_W'(value);
         CSR_QUALITY_MAX:  win_qmax = QUAL_W'(value);
         CSR_DISTANCE_MIN: win_dmin = DIST_W'(value);
         CSR_DISTANCE_MAX: win_dmax = DIST_W'(value);
      endcase
   endtask

   // Only called with the block idle (after drain_means).
   task automatic set_windows(input int qmin, input int qmax, input int dmin, input int dmax);
      write_csr(CSR_QUALITY_MIN, qmin);
      write_csr(CSR_QUALITY_MAX, qmax);
      write_csr(CSR_DISTANCE_MIN, dmin);
      write_csr(CSR_DISTANCE_MAX, dmax);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Reset windows: both edges of each window, sector boundaries 0/1, 1/2, 6/7, 7/0, angles past 360 deg.
   task automatic test_window_and_sector_bounds();
      send_point(600, 0, 10);          // lowest kept distance and quality
      send_point(40000, 1439, 25);     // highest kept, last angle of sector 0
      send_point(599, 1440, 10);       // just short
      send_point(40001, 1440, 25);     // just far
      send_point(1000, 1440, 9);       // quality just low
      send_point(1000, 1440, 26);      // quality just high
      send_point(1000, 1440, 15);      // first angle of sector 1
      send_point(1000, 4319, 15);
      send_point(1000, 4320, 15);      // sector 2 starts
      send_point(1000, 18719, 20);     // last of sector 6
      send_point(1000, 18720, 20);     // sector 7 starts
      send_point(1000, 21599, 15);     // last of sector 7
      send_point(1000, 21600, 15);     // wrap into sector 0
      send_point(1000, 23039, 15);
      send_point(1000, 23040, 15);     // out of range angle lands in sector 0
      send_point(1000, 32767, 15);
      send_point(65535, 32767, 63);    // all ones, dropped
      send_point(0, 0, 0);             // all zeros, dropped
      drain_means();
   endtask

   // Inverted windows keep nothing, so nothing may come out.
   task automatic test_empty_windows();
      set_windows(40, 20, 0, 65535);
      repeat (30) send_noise();
      drain_means();
      set_windows(0, 63, 50000, 1000);
      repeat (30) send_noise();
      drain_means();
   endtask

   // Phases cycle through open, reset, single-value, far-distance and random windows. One phase runs
   // with no gaps at all. Runs until the point budget is spent, with a cap on phases.
   task automatic test_random_windows();
      int phase, sent, q_lo, d_lo, hot;
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_POINTS && phase < 40) begin
         case (phase % 6)
            0: set_windows(0, 63, 0, 65535);
            1: set_windows(QUALITY_MIN_RST, QUALITY_MAX_RST, DISTANCE_MIN_RST, DISTANCE_MAX_RST);
            2: set_windows(63, 63, 65535, 65535);   // full-scale sums
            3: set_windows(0, 0, 0, 0);
            4: set_windows(0, 63, 60000, 65535);
            default: begin
               q_lo = $urandom_range(63, 0);
               d_lo = $urandom_range(65535, 0);
               set_windows(q_lo, $urandom_range(63, q_lo), d_lo, $urandom_range(65535, d_lo));
            end
         endcase
         idle_on = (phase != 1);
         hot     = $urandom_range(7, 0);
         repeat (PHASE_POINTS) begin
            if ($urandom_range(99, 0) < 85) begin
               send_binned(hot);
            end else begin
               send_noise();
            end
            sent++;
         end
         drain_means();
         phase++;
      end
      idle_on = 1'b1;
   endtask

   // Receiver holds off while points keep coming: the block fills and drops req_ready.
   // Then the sender waits for every mean before a second burst.
   task automatic test_result_backpressure();
      int hot;
      set_windows(0, 63, 0, 65535);
      hot = $urandom_range(7, 0);
      rsp_hold_request = HOLD_CYCLES;
      repeat (120) send_binned(hot);
      drain_means();
      repeat (40) send_binned(hot);
      drain_means();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_window_and_sector_bounds();
      test_empty_windows();
      test_random_windows();
      test_result_backpressure();

      $display("%0d point beats over %0d window settings, %0d sector means checked",
               points_taken, settings_used, means_checked);
      $display("edges, wrap and out-of-range angles, empty windows, %0d-cycle rsp hold",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_means.size() == 0) begin
         $display("lidar_sector_binning_average: match");
      end else begin
         $display("%0d failures, %0d means left", mismatch_count, pending_means.size());
         $display("lidar_sector_binning_average: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/lsba_pkg.sv
rtl/lsba_front.sv
rtl/lsba_queue.sv
rtl/lsba_back.sv
rtl/lidar_sector_binning_average.sv
tb/sv/testbench.sv
